/* rtl/bqf_pkg.sv */
// bqf_pkg: shared types, register codes and saturation helpers for the biquad filter
// no dependencies; imported by the filter top level, its state memory and the checker
`timescale 1ns / 1ps

package bqf_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 28;
    localparam int STATE_W  = 40;
    localparam int CHAN_W   = 4;
    localparam int WIN_W    = 5;
    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int IDX_W    = 3;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_B0    = 3'd0,
        REG_B1    = 3'd1,
        REG_B2    = 3'd2,
        REG_A1    = 3'd3,
        REG_A2    = 3'd4,
        REG_FIRST = 3'd5,
        REG_END   = 3'd6
    } bqf_reg_t;

    // sequencer states, one multiplier product per state from the read through ST_MA2
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MB1,
        ST_MA1,
        ST_MB2,
        ST_MA2,
        ST_DONE
    } bqf_state_t;

    // clamp a Q9.23 32-bit value to the Q1.23 sample range
    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [31:0] v);
        logic hi_ok;
        hi_ok = (v[31:SAMPLE_W-1] == '0) || (v[31:SAMPLE_W-1] == '1);
        if (hi_ok)
            return v[SAMPLE_W-1:0];
        else if (v[31])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    // clamp a 41-bit sum to the 40-bit delay word range
    function automatic logic [STATE_W-1:0] sat_state(input logic [STATE_W:0] v);
        if (v[STATE_W] == v[STATE_W-1])
            return v[STATE_W-1:0];
        else if (v[STATE_W])
            return {1'b1, {(STATE_W-1){1'b0}}};
        else
            return {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

endpackage

/* rtl/multichannel_biquad_filter.sv */
// multichannel_biquad_filter: top level, config registers, sequencer and datapath
// depends on bqf_pkg and bqf_state_mem
`timescale 1ns / 1ps

// Transposed direct form II biquad shared by up to CHANNELS audio channels. Each
// channel's two delay words live in one synchronous memory entry; a sample is
// read, filtered and written back before the next one is taken, so accesses to
// the same entry never overlap. A sample inside the channel window has its
// memory read issued on acceptance; the single shared 28x24 multiplier then
// forms b0*x, b1*x, a1*y, b2*x and a2*y in turn, and the delay words are
// written back as the result enters the output register, which may wait on
// a stalled sink; only then can the next sample be accepted. A sample outside
// the window is dropped with no result. The delay store reads as zero after reset
// through per-entry written flags, so there is no clearing pass. Configuration
// writes are always ready and must be issued only while no item is in flight.
module multichannel_biquad_filter
    import bqf_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // sample input
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CHAN_W-1:0]          channel,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    // filtered output
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CHAN_W-1:0]          out_channel,
    output logic signed [SAMPLE_W-1:0] out_sample,
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [COEF_W-1:0]          cfg_data
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = 9;
    localparam int SUM_W = PROD_W + 1;
    localparam int SH    = 15;

    // configuration
    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [WIN_W-1:0]         first_reg, end_reg;

    // sequencer
    bqf_state_t state_reg, state_next;
    logic       accept, in_win, done_fire;

    // datapath
    logic [CHAN_W-1:0]          ch_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [SUM_W-1:0]           t_reg;
    logic [STATE_W-1:0]         s1_reg;
    logic signed [COEF_W-1:0]   mul_coef;
    logic signed [SAMPLE_W-1:0] mul_smp;
    logic [EXT_W-1:0]           chan_ext;
    logic [EXT_W-1:0]           ch_reg_ext;
    logic [AW-1:0]              addr;
    logic [AW-1:0]              wr_addr;
    logic [2*STATE_W-1:0]       rd_data, wr_data;
    logic [STATE_W-1:0]         d1, d2;
    logic [STATE_W:0]           acc_sum, s1_sum;
    logic [SUM_W-1:0]           s2_diff, prod_ext;
    logic [STATE_W-1:0]         s2_word;

    // output register
    logic                       out_valid_reg;
    logic [CHAN_W-1:0]          out_channel_reg;
    logic [SAMPLE_W-1:0]        out_sample_reg;

    // config write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg    <= COEF_W'(28'sd16777216);
            b1_reg    <= '0;
            b2_reg    <= '0;
            a1_reg    <= '0;
            a2_reg    <= '0;
            first_reg <= '0;
            end_reg   <= WIN_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bqf_reg_t'(cfg_index))
                REG_B0:    b0_reg    <= cfg_data;
                REG_B1:    b1_reg    <= cfg_data;
                REG_B2:    b2_reg    <= cfg_data;
                REG_A1:    a1_reg    <= cfg_data;
                REG_A2:    a2_reg    <= cfg_data;
                REG_FIRST: first_reg <= cfg_data[WIN_W-1:0];
                REG_END:   end_reg   <= cfg_data[WIN_W-1:0];
                default:   ;
            endcase
        end
    end

    // channel window check and memory address
    assign chan_ext = {{(EXT_W-CHAN_W){1'b0}}, channel};
    assign addr     = chan_ext[AW-1:0];
    assign in_win   = ({1'b0, channel} >= first_reg) && ({1'b0, channel} < end_reg)
                      && (chan_ext < EXT_W'(CHANNELS));
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && in_win) state_next = ST_READ;
            ST_READ: state_next = ST_MB1;
            ST_MB1:  state_next = ST_MA1;
            ST_MA1:  state_next = ST_MB2;
            ST_MB2:  state_next = ST_MA2;
            ST_MA2:  state_next = ST_DONE;
            ST_DONE: if (done_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_coef = b0_reg;
        mul_smp  = x_reg;
        unique case (state_reg)
            ST_READ: begin mul_coef = b0_reg; mul_smp = x_reg; end
            ST_MB1:  begin mul_coef = b1_reg; mul_smp = x_reg; end
            ST_MA1:  begin mul_coef = a1_reg; mul_smp = y_reg; end
            ST_MB2:  begin mul_coef = b2_reg; mul_smp = x_reg; end
            ST_MA2:  begin mul_coef = a2_reg; mul_smp = y_reg; end
            default: begin mul_coef = b0_reg; mul_smp = x_reg; end
        endcase
    end

    assign prod_next = mul_coef * mul_smp;

    // delay words from the store
    assign d1 = rd_data[2*STATE_W-1:STATE_W];
    assign d2 = rd_data[STATE_W-1:0];

    // y accumulate: floor(b0*x / 2^15) + s1, then floor by 2^9 and clamp in sat_sample
    assign acc_sum = {{(STATE_W+1-(PROD_W-SH)){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:SH]}
                     + {d1[STATE_W-1], d1};
    // new first delay: floor((b1*x - a1*y) / 2^15) + s2
    assign s1_sum  = {{(STATE_W+1-(SUM_W-SH)){t_reg[SUM_W-1]}}, t_reg[SUM_W-1:SH]}
                     + {d2[STATE_W-1], d2};
    // new second delay: floor((b2*x - a2*y) / 2^15), always in range
    assign prod_ext = {prod_reg[PROD_W-1], prod_reg};
    assign s2_diff  = t_reg - prod_ext;
    assign s2_word  = {{(STATE_W-(SUM_W-SH)){s2_diff[SUM_W-1]}}, s2_diff[SUM_W-1:SH]};

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= channel;
            x_reg  <= in_sample;
        end
        // a2*y stays put while the result waits for the output register
        if (state_reg != ST_DONE)
            prod_reg <= prod_next;
        unique case (state_reg)
            ST_MB1:  y_reg  <= sat_sample(acc_sum[STATE_W:9]);
            ST_MA1:  t_reg  <= prod_ext;
            ST_MB2:  t_reg  <= t_reg - prod_ext;
            ST_MA2:
            begin
                s1_reg <= sat_state(s1_sum);
                t_reg  <= prod_ext;
            end
            default: ;
        endcase
    end

    // result register, frees the sequencer while the sink stalls unless it already holds a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            out_channel_reg <= ch_reg;
            out_sample_reg  <= y_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_sample  = out_sample_reg;

    // delay word store, written back when the result is handed over
    assign wr_data    = {s1_reg, s2_word};
    assign ch_reg_ext = {{(EXT_W-CHAN_W){1'b0}}, ch_reg};
    assign wr_addr    = ch_reg_ext[AW-1:0];

    bqf_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_win),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_en   (done_fire),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

/* rtl/bqf_state_mem.sv */
// bqf_state_mem: per-channel delay word store, both delay words in one entry
// depends on bqf_pkg for the delay word width
`timescale 1ns / 1ps

module bqf_state_mem
    import bqf_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [2*STATE_W-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [2*STATE_W-1:0] wr_data
);

    logic [2*STATE_W-1:0] mem [DEPTH];
    logic [2*STATE_W-1:0] data_reg;
    logic [DEPTH-1:0]     vld_reg;
    logic                 hit_reg;

    // storage array, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            data_reg <= mem[rd_addr];
    end

    // written flags, cleared by reset so untouched channels read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                hit_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

/* rtl/bqf_checker.sv */
// bqf_checker: port-level assertions for the biquad filter, bound to the top level
// depends on bqf_pkg for field widths
`timescale 1ns / 1ps

module bqf_checker
    import bqf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [CHAN_W-1:0]   out_channel,
    input logic [SAMPLE_W-1:0] out_sample,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_sample) && $stable(out_channel))
        else $error("result payload changed while stalled");

    // a new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in flight");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind multichannel_biquad_filter bqf_checker u_bqf_checker (.*);
